[rtl/dwo_pkg.sv]
// Shared types, constants and the microcode table of the drawbar wavetable oscillator.
`timescale 1ns / 1ps

package dwo_pkg;

    localparam int DEF_NUM_PARTIALS = 9;

    localparam int TABLE_DEPTH = 257;
    localparam int TABLE_AW    = 9;
    localparam int WAVE_W      = 16;
    localparam int PHASE_W     = 32;
    localparam int GAIN_W      = 17;
    localparam int FRAC_W      = 16;
    localparam int SAMPLE_W    = 18;
    localparam int OUT_TDATA_W = 24;
    localparam int IN_TDATA_W  = 80;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Datapath widths: interpolated value, multiplier operand B, product, running sum.
    localparam int MIX_W      = 33;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MIX_W + MUL_B_W;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int GAIN_SHIFT = 32;

    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

    // Command codes carried in tuser.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_PARTIAL = 2'd1;
    localparam logic [1:0] CMD_TABLE   = 2'd2;

    // Register byte addresses.
    localparam logic [APB_AW-1:0] ADDR_PERCUSSIVE = 3'd0;

    typedef enum logic [1:0] {
        MUL_LO,
        MUL_HI,
        MUL_GAIN
    } t_mul_sel;

    typedef enum logic [1:0] {
        MIX_HOLD,
        MIX_LOAD,
        MIX_ADD
    } t_mix_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_EMIT
    } t_jump;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     addr_hi;
        t_mix_op  mix_op;
        logic     acc_en;
        t_jump    jump;
    } t_uword;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     addr_hi;
        t_mix_op  mix_op;
        logic     acc_en;
        logic     clear;
    } t_dp_ctrl;

    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UPC_FETCH_LO = 3'd0;
    localparam logic [UPC_W-1:0] UPC_FETCH_HI = 3'd1;
    localparam logic [UPC_W-1:0] UPC_MIX_HI   = 3'd2;
    localparam logic [UPC_W-1:0] UPC_SCALE    = 3'd3;
    localparam logic [UPC_W-1:0] UPC_EMIT     = 3'd4;

    // Microcode ROM. The table read is registered, so each step sees the data
    // addressed by the step before it.
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        case (pc)
            UPC_FETCH_LO: ucode = '{MUL_LO,   1'b0, MIX_HOLD, 1'b0, JMP_NEXT};
            UPC_FETCH_HI: ucode = '{MUL_LO,   1'b1, MIX_LOAD, 1'b0, JMP_NEXT};
            UPC_MIX_HI:   ucode = '{MUL_HI,   1'b0, MIX_ADD,  1'b0, JMP_NEXT};
            UPC_SCALE:    ucode = '{MUL_GAIN, 1'b0, MIX_HOLD, 1'b1, JMP_LOOP};
            UPC_EMIT:     ucode = '{MUL_GAIN, 1'b0, MIX_HOLD, 1'b0, JMP_EMIT};
            default:      ucode = '{MUL_GAIN, 1'b0, MIX_HOLD, 1'b0, JMP_EMIT};
        endcase
    endfunction

endpackage

[rtl/dwo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dwo_sequencer.sv]
// Microcode sequencer: step counter, partial counter and jump logic.
`timescale 1ns / 1ps

module dwo_sequencer #(
    parameter int NUM_PARTIALS = dwo_pkg::DEF_NUM_PARTIALS,
    localparam int PW = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_percussive,
    input  logic              i_out_free,
    output logic              o_busy,
    output logic              o_emit,
    output logic [PW-1:0]     o_part,
    output dwo_pkg::t_dp_ctrl o_ctrl
);

    logic                      r_busy, n_busy;
    logic [dwo_pkg::UPC_W-1:0] r_pc, n_pc;
    logic [PW-1:0]             r_part, n_part;
    dwo_pkg::t_uword           w;
    logic                      last_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= dwo_pkg::UPC_FETCH_LO;
            r_part <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_part <= n_part;
        end
    end

    // In percussive mode only the first partial is run.
    assign last_part = i_percussive || (r_part == PW'(NUM_PARTIALS - 1));

    always_comb begin
        w      = dwo_pkg::ucode(r_pc);
        n_busy = r_busy;
        n_pc   = r_pc;
        n_part = r_part;
        o_emit = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = dwo_pkg::UPC_FETCH_LO;
            n_part = '0;
        end else if (r_busy) begin
            case (w.jump)
                dwo_pkg::JMP_NEXT: begin
                    n_pc = r_pc + 1'b1;
                end
                dwo_pkg::JMP_LOOP: begin
                    if (last_part) begin
                        n_pc = r_pc + 1'b1;
                    end else begin
                        n_pc   = dwo_pkg::UPC_FETCH_LO;
                        n_part = r_part + 1'b1;
                    end
                end
                dwo_pkg::JMP_EMIT: begin
                    if (i_out_free) begin
                        o_emit = 1'b1;
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_ctrl.mul_sel = w.mul_sel;
        o_ctrl.addr_hi = w.addr_hi;
        o_ctrl.mix_op  = r_busy ? w.mix_op : dwo_pkg::MIX_HOLD;
        o_ctrl.acc_en  = r_busy && w.acc_en;
        o_ctrl.clear   = i_start;
    end

    assign o_busy = r_busy;
    assign o_part = r_part;

endmodule

[rtl/dwo_datapath.sv]
// Oscillator datapath: partial state, shared multiplier, interpolator and mixer.
`timescale 1ns / 1ps

module dwo_datapath #(
    parameter int NUM_PARTIALS = dwo_pkg::DEF_NUM_PARTIALS,
    localparam int PW = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dwo_pkg::t_dp_ctrl                   i_ctrl,
    input  logic [PW-1:0]                       i_part,
    input  logic                                i_percussive,
    input  logic                                i_wr_en,
    input  logic [PW-1:0]                       i_wr_index,
    input  logic [dwo_pkg::PHASE_W-1:0]         i_wr_step,
    input  logic [dwo_pkg::GAIN_W-1:0]          i_wr_gain,
    output logic [dwo_pkg::TABLE_AW-1:0]        o_raddr,
    input  logic signed [dwo_pkg::WAVE_W-1:0]   i_rdata,
    output logic [dwo_pkg::SAMPLE_W-1:0]        o_sample
);

    logic [dwo_pkg::PHASE_W-1:0] r_phase [NUM_PARTIALS];
    logic [dwo_pkg::PHASE_W-1:0] r_step  [NUM_PARTIALS];
    logic [dwo_pkg::GAIN_W-1:0]  r_gain  [NUM_PARTIALS];

    logic signed [dwo_pkg::MIX_W-1:0]   r_mix;
    logic signed [dwo_pkg::SUM_W-1:0]   r_sum;
    logic [dwo_pkg::TABLE_AW-2:0]       idx;
    logic [dwo_pkg::FRAC_W-1:0]         frac;
    logic signed [dwo_pkg::MIX_W-1:0]   mul_a;
    logic signed [dwo_pkg::MUL_B_W-1:0] mul_b;
    logic signed [dwo_pkg::PROD_W-1:0]  prod;
    logic signed [dwo_pkg::SUM_W-1:0]   term;
    logic signed [dwo_pkg::MIX_W-1:0]   wave_ext;

    assign idx  = r_phase[i_part][dwo_pkg::PHASE_W-1 -: (dwo_pkg::TABLE_AW - 1)];
    assign frac = r_phase[i_part][dwo_pkg::PHASE_W-dwo_pkg::TABLE_AW -: dwo_pkg::FRAC_W];

    assign o_raddr = {1'b0, idx} + dwo_pkg::TABLE_AW'(i_ctrl.addr_hi);

    assign wave_ext = {{(dwo_pkg::MIX_W - dwo_pkg::WAVE_W){i_rdata[dwo_pkg::WAVE_W-1]}}, i_rdata};

    always_comb begin
        case (i_ctrl.mul_sel)
            dwo_pkg::MUL_LO: begin
                mul_a = wave_ext;
                mul_b = {1'b0, dwo_pkg::FRAC_ONE - {1'b0, frac}};
            end
            dwo_pkg::MUL_HI: begin
                mul_a = wave_ext;
                mul_b = {2'b00, frac};
            end
            dwo_pkg::MUL_GAIN: begin
                mul_a = r_mix;
                mul_b = {1'b0, r_gain[i_part]};
            end
            default: begin
                mul_a = r_mix;
                mul_b = {1'b0, r_gain[i_part]};
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    // Arithmetic shift gives the floor; the sum only needs its low bits modulo 2^SUM_W.
    assign term = dwo_pkg::SUM_W'(prod >>> dwo_pkg::GAIN_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                r_phase[p] <= '0;
                r_step[p]  <= '0;
                r_gain[p]  <= '0;
            end
        end else begin
            if (i_wr_en) begin
                r_step[i_wr_index] <= i_wr_step;
                r_gain[i_wr_index] <= i_wr_gain;
            end
            if (i_ctrl.acc_en) begin
                r_phase[i_part] <= r_phase[i_part] + r_step[i_part];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.mix_op)
            dwo_pkg::MIX_LOAD: r_mix <= prod[dwo_pkg::MIX_W-1:0];
            dwo_pkg::MIX_ADD:  r_mix <= r_mix + prod[dwo_pkg::MIX_W-1:0];
            default:           r_mix <= r_mix;
        endcase
        if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.acc_en) begin
            r_sum <= r_sum + term;
        end
    end

    assign o_sample = i_percussive ? r_sum[dwo_pkg::SAMPLE_W-1:0]
                                   : r_sum[dwo_pkg::SAMPLE_W+1:2];

endmodule

[rtl/drawbar_wavetable_oscillator_core.sv]
// Top level of the drawbar wavetable oscillator: stream ports, register port, output stage.
`timescale 1ns / 1ps

// Additive organ voice of NUM_PARTIALS wavetable partials sharing one 257-entry table.
// Step/level writes (tuser 1) and table writes (tuser 2) are taken while idle. A tick
// (tuser 0) with note_on set runs a five-step microprogram on one multiplier and the
// single read port of the wave-table RAM: four steps per partial (two table reads, two
// interpolation products, one level product with accumulate), then one step that hands
// the sample to the output register once it is free. The input is held off while a
// sounding tick runs (only the first partial runs in percussive mode); a tick with
// note_on clear gives no sample. The output register lets the next transaction be taken
// while a sample waits downstream. Table entries must be written before a tick reads them.
module drawbar_wavetable_oscillator_core #(
    parameter int NUM_PARTIALS = dwo_pkg::DEF_NUM_PARTIALS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: note_on[0], partial_index[4:1], phase_step[36:5],
    // partial_level[53:37], table_address[62:54], table_value[78:63], zero pad [79].
    input  logic [dwo_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [1:0]                         s_axis_tuser,
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: sample[17:0], zero pad [23:18].
    output logic [dwo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dwo_pkg::APB_AW-1:0]         paddr,
    input  logic [dwo_pkg::APB_DW-1:0]         pwdata,
    output logic [dwo_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int PW = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;

    logic                                r_percussive;
    logic                                r_out_valid;
    logic [dwo_pkg::SAMPLE_W-1:0]        r_out_sample;

    logic                                in_accept;
    logic                                start;
    logic                                wr_partial;
    logic                                wr_table;
    logic                                out_free;
    logic                                seq_busy;
    logic                                seq_emit;
    logic [PW-1:0]                       part;
    dwo_pkg::t_dp_ctrl                   ctrl;
    logic [dwo_pkg::TABLE_AW-1:0]        raddr;
    logic signed [dwo_pkg::WAVE_W-1:0]   rdata;
    logic [dwo_pkg::SAMPLE_W-1:0]        sample;

    logic [1:0]                          in_cmd;
    logic                                in_note_on;
    logic [3:0]                          in_partial_index;
    logic [dwo_pkg::PHASE_W-1:0]         in_phase_step;
    logic [dwo_pkg::GAIN_W-1:0]          in_partial_level;
    logic [dwo_pkg::TABLE_AW-1:0]        in_table_address;
    logic [dwo_pkg::WAVE_W-1:0]          in_table_value;

    assign in_cmd           = s_axis_tuser;
    assign in_note_on       = s_axis_tdata[0];
    assign in_partial_index = s_axis_tdata[4:1];
    assign in_phase_step    = s_axis_tdata[36:5];
    assign in_partial_level = s_axis_tdata[53:37];
    assign in_table_address = s_axis_tdata[62:54];
    assign in_table_value   = s_axis_tdata[78:63];

    assign s_axis_tready = !seq_busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign start      = in_accept && (in_cmd == dwo_pkg::CMD_TICK) && in_note_on;
    assign wr_partial = in_accept && (in_cmd == dwo_pkg::CMD_PARTIAL)
                        && ({1'b0, in_partial_index} < 5'(NUM_PARTIALS));
    assign wr_table   = in_accept && (in_cmd == dwo_pkg::CMD_TABLE)
                        && (in_table_address < dwo_pkg::TABLE_AW'(dwo_pkg::TABLE_DEPTH));

    // Register port: only the percussive bit exists; it decodes on the word address bit.
    assign pready = 1'b1;
    assign prdata = (paddr[dwo_pkg::APB_AW-1] == dwo_pkg::ADDR_PERCUSSIVE[dwo_pkg::APB_AW-1])
                    ? {{(dwo_pkg::APB_DW-1){1'b0}}, r_percussive} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_percussive <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[dwo_pkg::APB_AW-1]
                         == dwo_pkg::ADDR_PERCUSSIVE[dwo_pkg::APB_AW-1])) begin
            r_percussive <= pwdata[0];
        end
    end

    // Output register.
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_emit) begin
            r_out_sample <= sample;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(dwo_pkg::OUT_TDATA_W - dwo_pkg::SAMPLE_W){1'b0}}, r_out_sample};

    dwo_sequencer #(
        .NUM_PARTIALS (NUM_PARTIALS)
    ) u_sequencer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_percussive (r_percussive),
        .i_out_free   (out_free),
        .o_busy       (seq_busy),
        .o_emit       (seq_emit),
        .o_part       (part),
        .o_ctrl       (ctrl)
    );

    dwo_datapath #(
        .NUM_PARTIALS (NUM_PARTIALS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_part       (part),
        .i_percussive (r_percussive),
        .i_wr_en      (wr_partial),
        .i_wr_index   (in_partial_index[PW-1:0]),
        .i_wr_step    (in_phase_step),
        .i_wr_gain    (in_partial_level),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_sample     (sample)
    );

    dwo_ram #(
        .WIDTH (dwo_pkg::WAVE_W),
        .DEPTH (dwo_pkg::TABLE_DEPTH)
    ) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (wr_table),
        .i_waddr (in_table_address),
        .i_wdata (in_table_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // A sounding tick always starts the sequencer.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> seq_busy)
        else $error("sounding tick did not start the sequencer");

    // A sample is never handed over while the output register holds one that is not being taken.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_emit |-> out_free)
        else $error("sample emitted over a pending result");

    // The partial counter never runs past the last partial.
    a_part_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_busy |-> ({1'b0, part} < (PW + 1)'(NUM_PARTIALS)))
        else $error("partial counter out of range");

endmodule

[verif/testbench.sv]
// Self-checking testbench of the drawbar wavetable oscillator core.
`timescale 1ns / 1ps

module testbench;

    localparam int          NUM_PARTIALS = dwo_pkg::DEF_NUM_PARTIALS;
    localparam logic [1:0]  CMD_RESERVED = 2'd3;
    // Idle tail after draining, with margin over the length of a sounding tick.
    localparam int          TAIL_CYCLES  = 4 * NUM_PARTIALS + 14;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_ITEMS = 250;

    typedef struct {
        logic [1:0]                        cmd;
        logic                              note_on;
        logic [3:0]                        partial_index;
        logic [dwo_pkg::PHASE_W-1:0]       phase_step;
        logic [dwo_pkg::GAIN_W-1:0]        partial_level;
        logic [dwo_pkg::TABLE_AW-1:0]      table_address;
        logic signed [dwo_pkg::WAVE_W-1:0] table_value;
    } t_osc_item;

    class t_sample_scoreboard;
        logic [dwo_pkg::PHASE_W-1:0]       phase   [NUM_PARTIALS];
        logic [dwo_pkg::PHASE_W-1:0]       step    [NUM_PARTIALS];
        logic [dwo_pkg::GAIN_W-1:0]        gain    [NUM_PARTIALS];
        logic signed [dwo_pkg::WAVE_W-1:0] wave    [dwo_pkg::TABLE_DEPTH];
        bit                                percussive;
        logic [dwo_pkg::SAMPLE_W-1:0]      pending [$];
        int                                errors;
        int                                samples_checked;
        int                                inputs_taken;

        function new();
            foreach (phase[p]) begin
                phase[p] = '0;
                step[p]  = '0;
                gain[p]  = '0;
            end
            foreach (wave[a]) begin
                wave[a] = '0;
            end
            percussive      = 1'b0;
            errors          = 0;
            samples_checked = 0;
            inputs_taken    = 0;
        endfunction

        // Interpolate between two neighboring table entries, then scale by the level.
        function longint partial_out(int p);
            longint frac, lo, hi, mix;
            frac = longint'(phase[p][23:8]);
            lo   = wave[phase[p][31:24]];
            hi   = wave[phase[p][31:24] + 9'd1];
            mix  = lo * (longint'(dwo_pkg::FRAC_ONE) - frac) + hi * frac;
            return (mix * longint'(gain[p])) >>> dwo_pkg::GAIN_SHIFT;
        endfunction

        function logic [dwo_pkg::SAMPLE_W-1:0] next_sample();
            longint total;
            int     sounding;
            total    = 0;
            sounding = percussive ? 1 : NUM_PARTIALS;
            for (int p = 0; p < sounding; p++) begin
                total += partial_out(p);
            end
            if (!percussive) begin
                total = total >>> 2;
            end
            for (int p = 0; p < sounding; p++) begin
                phase[p] += step[p];
            end
            return total[dwo_pkg::SAMPLE_W-1:0];
        endfunction

        function void take_input(t_osc_item it);
            inputs_taken++;
            case (it.cmd)
                dwo_pkg::CMD_PARTIAL: begin
                    if (it.partial_index < NUM_PARTIALS) begin
                        step[it.partial_index] = it.phase_step;
                        gain[it.partial_index] = it.partial_level;
                    end
                end
                dwo_pkg::CMD_TABLE: begin
                    if (it.table_address < dwo_pkg::TABLE_DEPTH) begin
                        wave[it.table_address] = it.table_value;
                    end
                end
                dwo_pkg::CMD_TICK: begin
                    if (it.note_on) begin
                        pending.push_back(next_sample());
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [dwo_pkg::SAMPLE_W-1:0] got);
            logic [dwo_pkg::SAMPLE_W-1:0] want;
            if (pending.size() == 0) begin
                $error("sample: none expected, actual %0d", $signed(got));
                errors++;
            end else begin
                want = pending.pop_front();
                samples_checked++;
                if (want !== got) begin
                    $error("sample: expected %0d, actual %0d", $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [dwo_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic [1:0]                         s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [dwo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [dwo_pkg::APB_AW-1:0]         paddr;
    logic [dwo_pkg::APB_DW-1:0]         pwdata;
    logic [dwo_pkg::APB_DW-1:0]         prdata;
    logic                               pready;

    t_sample_scoreboard board;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 cycles;

    drawbar_wavetable_oscillator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Output side: check every sample transaction and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_sample(m_axis_tdata[dwo_pkg::SAMPLE_W-1:0]);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_osc_item make_item(logic [1:0] cmd, logic note_on,
                                            logic [3:0] partial_index,
                                            logic [dwo_pkg::PHASE_W-1:0] phase_step,
                                            logic [dwo_pkg::GAIN_W-1:0] partial_level,
                                            logic [dwo_pkg::TABLE_AW-1:0] table_address,
                                            logic [dwo_pkg::WAVE_W-1:0] table_value);
        t_osc_item it;
        it.cmd           = cmd;
        it.note_on       = note_on;
        it.partial_index = partial_index;
        it.phase_step    = phase_step;
        it.partial_level = partial_level;
        it.table_address = table_address;
        it.table_value   = table_value;
        return it;
    endfunction

    function automatic t_osc_item random_item();
        t_osc_item it;
        int        pick;
        it = make_item(dwo_pkg::CMD_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)),
                       $urandom, 17'($urandom_range(131071)), 9'($urandom_range(511)),
                       16'($urandom_range(65535)));
        if ($urandom_range(3) == 0) begin
            it.phase_step = $urandom_range(65535);
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
            it.note_on = 1'b1;
        end else if (pick < 60) begin
            it.note_on = 1'b0;
        end else if (pick < 80) begin
            it.cmd = dwo_pkg::CMD_PARTIAL;
            if ($urandom_range(9) != 0) begin
                it.partial_index = 4'($urandom_range(NUM_PARTIALS - 1));
            end
            if ($urandom_range(3) != 0) begin
                it.partial_level = 17'($urandom_range(65536));
            end
        end else if (pick < 95) begin
            it.cmd = dwo_pkg::CMD_TABLE;
            if ($urandom_range(9) != 0) begin
                it.table_address = 9'($urandom_range(dwo_pkg::TABLE_DEPTH - 1));
            end
        end else begin
            it.cmd = CMD_RESERVED;
        end
        return it;
    endfunction

    // Entered at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_item(input t_osc_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {1'b0, it.table_value, it.table_address, it.partial_level,
                          it.phase_step, it.partial_index, it.note_on};
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_input(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write the mode register, then read it back.
    task automatic write_percussive(input bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dwo_pkg::ADDR_PERCUSSIVE;
        pwdata  <= {{(dwo_pkg::APB_DW-1){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.percussive = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {{(dwo_pkg::APB_DW-1){1'b0}}, value}) begin
            $error("percussive_only: expected %0d, actual %0d", value, prdata);
            board.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(input int count);
        t_osc_item it;
        int        useful;
        useful = 0;
        while (useful < count) begin
            it = random_item();
            send_item(it);
            if (!(it.cmd == CMD_RESERVED
                  || (it.cmd == dwo_pkg::CMD_TICK && !it.note_on)
                  || (it.cmd == dwo_pkg::CMD_PARTIAL && it.partial_index >= NUM_PARTIALS)
                  || (it.cmd == dwo_pkg::CMD_TABLE
                      && it.table_address >= dwo_pkg::TABLE_DEPTH))) begin
                useful++;
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = dwo_pkg::CMD_TICK;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = dwo_pkg::ADDR_PERCUSSIVE;
        pwdata         = '0;
        cycles         = 0;
        send_idle_pct  = 11;
        recv_stall_pct = 71;
        board          = new();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_percussive(1'b0);

        // Fill the whole table first so that no tick can read an unwritten entry.
        for (int a = 0; a < dwo_pkg::TABLE_DEPTH; a++) begin
            send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'(a),
                                16'($urandom_range(65535))));
        end

        // All levels are still zero, so the first sample is silence.
        send_item(make_item(dwo_pkg::CMD_TICK, 1'b1, 4'd0, 32'd0, 17'd0, 9'd0, 16'd0));
        send_item(make_item(dwo_pkg::CMD_TICK, 1'b0, 4'd0, 32'd0, 17'd0, 9'd0, 16'd0));
        send_item(make_item(CMD_RESERVED, 1'b1, 4'd0, 32'd0, 17'd0, 9'd0, 16'd0));
        send_item(make_item(dwo_pkg::CMD_PARTIAL, 1'b0, 4'd15, 32'hFFFF_FFFF, 17'h1FFFF,
                            9'd0, 16'd0));
        send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'd511, 16'h7FFF));
        send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'd257, 16'h8000));
        send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'd0, 16'h7FFF));
        send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'd1, 16'h8000));
        send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'd255, 16'h8000));
        send_item(make_item(dwo_pkg::CMD_TABLE, 1'b0, 4'd0, 32'd0, 17'd0, 9'd256, 16'h7FFF));
        // Partial one wraps straight to the last table segment; the first tick, with all but the
        // last partial at full level, overflows the 18-bit sum.
        send_item(make_item(dwo_pkg::CMD_PARTIAL, 1'b0, 4'd0, 32'hFFFF_FFFF, 17'h1FFFF,
                            9'd0, 16'd0));
        for (int p = 1; p < NUM_PARTIALS - 1; p++) begin
            send_item(make_item(dwo_pkg::CMD_PARTIAL, 1'b0, 4'(p), 32'(p) * 32'h0080_4321,
                                17'h1FFFF, 9'd0, 16'd0));
        end
        send_item(make_item(dwo_pkg::CMD_PARTIAL, 1'b0, 4'(NUM_PARTIALS - 1),
                            32'h0100_0000, dwo_pkg::FRAC_ONE, 9'd0, 16'd0));
        repeat (3) send_item(make_item(dwo_pkg::CMD_TICK, 1'b1, 4'd0, 32'd0, 17'd0, 9'd0,
                                       16'd0));
        drain();

        // Percussive ticks must leave the other phases where they were.
        write_percussive(1'b1);
        repeat (3) send_item(make_item(dwo_pkg::CMD_TICK, 1'b1, 4'd0, 32'd0, 17'd0, 9'd0,
                                       16'd0));

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct  = (mode == 0) ? 11 : (mode == 1) ? 71 : 0;
            recv_stall_pct = (mode == 0) ? 71 : (mode == 1) ? 11 : 0;
            for (int half = 0; half < 2; half++) begin
                drain();
                write_percussive(half[0]);
                run_random(RANDOM_ITEMS);
            end
        end
        drain();

        $display("Covered %0d input transactions and %0d checked samples,",
                 board.inputs_taken, board.samples_checked);
        $display("in both mixing modes and under three sender/receiver idle patterns.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

[drawbar_wavetable_oscillator_core.f]
rtl/dwo_pkg.sv
rtl/dwo_ram.sv
rtl/dwo_sequencer.sv
rtl/dwo_datapath.sv
rtl/drawbar_wavetable_oscillator_core.sv
verif/testbench.sv
